>>> hdl/art_pkg.sv
// shared types and constants of the address range match table
`default_nettype none

package art_pkg;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE   = 1'b0;
    localparam logic REG_OWN_NODE = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BADNODE  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_DISABLED = 2'd3;

    typedef enum logic [2:0] {
        FN_REC_LOCAL  = 3'd0,
        FN_REC_NODE   = 3'd1,
        FN_FIND_LOCAL = 3'd2,
        FN_FIND_NODE  = 3'd3,
        FN_FIND_BOTH  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        PH_FIND,
        PH_BOTH_LOC,
        PH_BOTH_OWN,
        PH_BOTH_REM
    } phase_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  node;
        logic [47:0] addr;
        logic [47:0] remote_addr;
        logic [31:0] length;
    } in_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
        logic [1:0] status;
    } out_t;

endpackage

`default_nettype wire

>>> hdl/art_ram.sv
// generic single write port ram with registered read
`default_nettype none

module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/art_match.sv
// shared range compare unit: start <= key < end
`default_nettype none

module art_match #(
    parameter int ADDR_BITS = 48,
    parameter int END_BITS  = 49
) (
    input  wire logic [ADDR_BITS-1:0] range_start,
    input  wire logic [END_BITS-1:0]  range_end,
    input  wire logic [ADDR_BITS-1:0] key,
    output logic                      covers
);

    assign covers = (range_start <= key) && (range_end > END_BITS'(key));

endmodule

`default_nettype wire

>>> hdl/address_region_range_table_unit.sv
// address range match table: top level with sequencer, entry counts and config port
// records, errors and disabled lookups skip the scan and go from decode straight to the result state
// a lookup scans one entry per cycle and stops at the first hit or at the end of the list; find
// both runs up to three scans, and a record is written to the range ram in the decode state
// one item at a time; the next item is taken once the result sits in the output register
// reset clears the entry counts, enable, own_node and the handshake; the range ram is not
`default_nettype none

module address_region_range_table_unit #(
    parameter int NODES     = 16,
    parameter int SLOTS     = 8,
    parameter int ADDR_BITS = 48
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input item channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire art_pkg::in_t                      s_data,
    // result item channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output art_pkg::out_t                          m_data,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [art_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [art_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [art_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready
);

    // sizes derived from the parameters
    localparam int LISTS    = NODES + 1;
    localparam int LW       = $clog2(LISTS);
    localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW       = $clog2(SLOTS + 1);
    localparam int DEPTH    = LISTS * SLOTS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int END_BITS = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
    localparam int RW       = ADDR_BITS + END_BITS;

    localparam logic [LW-1:0] LOCAL_LIST = LW'(NODES);

    // configuration registers
    logic       enable_reg;
    logic [3:0] own_reg;

    // sequencer state
    art_pkg::state_t state_reg, state_next;
    art_pkg::phase_t phase_reg, phase_next;
    art_pkg::in_t    item_reg, item_next;
    logic [LW-1:0]        list_reg, list_next;
    logic [ADDR_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic [SW-1:0]        pend_idx_reg, pend_idx_next;
    art_pkg::out_t        res_reg, res_next;
    art_pkg::out_t        m_out_reg, m_out_next;
    logic                 m_valid_reg, m_valid_next;

    // per list fill counts
    logic [CW-1:0] cnt_reg [LISTS];
    logic          cnt_we;
    logic [CW-1:0] cnt_next;

    // decode of the held item
    logic [63:0]          addr_wide, raddr_wide;
    logic [ADDR_BITS-1:0] addr_key, raddr_key;
    logic                 bad_node, own_ok, full;
    logic [LW-1:0]        rec_list, cur_list;
    logic [CW-1:0]        cnt_cur;
    logic                 dec_scan, dec_rec;
    art_pkg::out_t        dec_res;
    logic [LW-1:0]        dec_list;
    art_pkg::phase_t      dec_phase;

    // scan step
    logic                 issue, covers, scan_hit, scan_end, scan_more;
    logic [LW-1:0]        more_list;
    logic [ADDR_BITS-1:0] more_key;
    art_pkg::phase_t      more_phase;
    art_pkg::out_t        scan_res;

    // range ram
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [RW-1:0]        ram_wdata, ram_rdata;
    logic [END_BITS-1:0]  rec_end;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_comb begin
        if (paddr[2] == art_pkg::REG_OWN_NODE) begin
            prdata = art_pkg::CFG_DATA_BITS'(own_reg);
        end else begin
            prdata = art_pkg::CFG_DATA_BITS'(enable_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            own_reg    <= 4'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == art_pkg::REG_ENABLE) begin
                enable_reg <= pwdata[0];
            end else begin
                own_reg <= pwdata[3:0];
            end
        end
    end

    // ---------------- item decode ----------------
    // addresses are cut to ADDR_BITS, zero extended first when ADDR_BITS is wider
    assign addr_wide  = 64'(item_reg.addr);
    assign raddr_wide = 64'(item_reg.remote_addr);
    assign addr_key   = addr_wide[ADDR_BITS-1:0];
    assign raddr_key  = raddr_wide[ADDR_BITS-1:0];

    assign bad_node = 32'(item_reg.node) >= NODES;
    assign own_ok   = 32'(own_reg) < NODES;
    assign rec_list = (item_reg.func == art_pkg::FN_REC_LOCAL) ? LOCAL_LIST
                                                                : LW'(item_reg.node);

    // count port: record list while decoding, scanned list otherwise
    assign cur_list = (state_reg == art_pkg::S_DECODE) ? rec_list : list_reg;
    assign cnt_cur  = (32'(cur_list) < LISTS) ? cnt_reg[cur_list] : '0;
    assign full     = cnt_cur >= CW'(SLOTS);

    always_comb begin
        dec_scan  = 1'b0;
        dec_rec   = 1'b0;
        dec_res   = '{hit: 1'b0, slot: 3'd0, status: art_pkg::STAT_OK};
        dec_list  = LOCAL_LIST;
        dec_phase = art_pkg::PH_FIND;
        case (item_reg.func)
            art_pkg::FN_REC_LOCAL: begin
                if (!enable_reg) begin
                    dec_res.status = art_pkg::STAT_DISABLED;
                end else if (full) begin
                    dec_res.status = art_pkg::STAT_FULL;
                end else begin
                    dec_rec     = 1'b1;
                    dec_res.hit = 1'b1;
                    dec_res.slot = 3'(cnt_cur);
                end
            end
            art_pkg::FN_REC_NODE: begin
                // node records do not depend on enable
                if (bad_node) begin
                    dec_res.status = art_pkg::STAT_BADNODE;
                end else if (full) begin
                    dec_res.status = art_pkg::STAT_FULL;
                end else begin
                    dec_rec     = 1'b1;
                    dec_res.hit = 1'b1;
                    dec_res.slot = 3'(cnt_cur);
                end
            end
            art_pkg::FN_FIND_LOCAL: begin
                if (!enable_reg) begin
                    dec_res.status = art_pkg::STAT_DISABLED;
                end else begin
                    dec_scan = 1'b1;
                end
            end
            art_pkg::FN_FIND_NODE: begin
                if (!enable_reg) begin
                    dec_res.status = art_pkg::STAT_DISABLED;
                end else if (bad_node) begin
                    dec_res.status = art_pkg::STAT_BADNODE;
                end else begin
                    dec_scan = 1'b1;
                    dec_list = LW'(item_reg.node);
                end
            end
            art_pkg::FN_FIND_BOTH: begin
                // local list first, then own node list, then remote in named node
                if (!enable_reg) begin
                    dec_res.status = art_pkg::STAT_DISABLED;
                end else if (bad_node) begin
                    dec_res.status = art_pkg::STAT_BADNODE;
                end else begin
                    dec_scan  = 1'b1;
                    dec_phase = art_pkg::PH_BOTH_LOC;
                end
            end
            default: begin
                // unknown func: plain miss, nothing changes
            end
        endcase
    end

    // ---------------- range store ----------------
    assign rec_end   = END_BITS'(addr_key) + END_BITS'(item_reg.length);
    assign ram_wdata = {rec_end, addr_key};
    assign ram_waddr = AW'(AW'(rec_list) * AW'(SLOTS) + AW'(cnt_cur));
    assign ram_raddr = AW'(AW'(list_reg) * AW'(SLOTS) + AW'(rd_idx_reg));

    art_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_range_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one entry per cycle through the shared comparator
    art_match #(
        .ADDR_BITS (ADDR_BITS),
        .END_BITS  (END_BITS)
    ) u_match (
        .range_start (ram_rdata[ADDR_BITS-1:0]),
        .range_end   (ram_rdata[RW-1:ADDR_BITS]),
        .key         (key_reg),
        .covers      (covers)
    );

    // ---------------- scan step ----------------
    // reads are issued while entries remain; the compare sees last cycle's read
    assign issue    = (state_reg == art_pkg::S_SCAN) && (rd_idx_reg < cnt_cur);
    assign scan_hit = pend_reg && covers;
    assign scan_end = scan_hit || !issue;

    always_comb begin
        scan_more  = 1'b0;
        more_list  = list_reg;
        more_key   = key_reg;
        more_phase = phase_reg;
        scan_res   = '{hit: 1'b0, slot: 3'd0, status: art_pkg::STAT_OK};
        case (phase_reg)
            art_pkg::PH_FIND: begin
                scan_res.hit  = scan_hit;
                scan_res.slot = scan_hit ? 3'(pend_idx_reg) : 3'd0;
            end
            art_pkg::PH_BOTH_LOC: begin
                if (scan_hit) begin
                    scan_more  = 1'b1;
                    more_list  = LW'(item_reg.node);
                    more_key   = raddr_key;
                    more_phase = art_pkg::PH_BOTH_REM;
                end else if (own_ok) begin
                    scan_more  = 1'b1;
                    more_list  = LW'(own_reg);
                    more_phase = art_pkg::PH_BOTH_OWN;
                end
            end
            art_pkg::PH_BOTH_OWN: begin
                if (scan_hit) begin
                    scan_more  = 1'b1;
                    more_list  = LW'(item_reg.node);
                    more_key   = raddr_key;
                    more_phase = art_pkg::PH_BOTH_REM;
                end
            end
            art_pkg::PH_BOTH_REM: begin
                scan_res.hit = scan_hit;
            end
            default: begin
            end
        endcase
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            art_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = art_pkg::S_DECODE;
                end
            end
            art_pkg::S_DECODE: begin
                state_next = dec_scan ? art_pkg::S_SCAN : art_pkg::S_RESULT;
            end
            art_pkg::S_SCAN: begin
                if (scan_end && !scan_more) begin
                    state_next = art_pkg::S_RESULT;
                end
            end
            art_pkg::S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = art_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = art_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs and datapath ----------------
    always_comb begin
        item_next     = item_reg;
        phase_next    = phase_reg;
        list_next     = list_reg;
        key_next      = key_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        res_next      = res_reg;
        m_out_next    = m_out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_we        = 1'b0;
        cnt_we        = 1'b0;
        cnt_next      = CW'(cnt_cur + CW'(1));
        case (state_reg)
            art_pkg::S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            art_pkg::S_DECODE: begin
                if (dec_scan) begin
                    list_next   = dec_list;
                    key_next    = addr_key;
                    phase_next  = dec_phase;
                    rd_idx_next = '0;
                end else begin
                    res_next = dec_res;
                    ram_we   = dec_rec;
                    cnt_we   = dec_rec;
                end
            end
            art_pkg::S_SCAN: begin
                if (issue) begin
                    rd_idx_next   = CW'(rd_idx_reg + CW'(1));
                    pend_next     = !scan_hit;
                    pend_idx_next = rd_idx_reg[SW-1:0];
                end
                if (scan_end) begin
                    if (scan_more) begin
                        list_next   = more_list;
                        key_next    = more_key;
                        phase_next  = more_phase;
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                    end else begin
                        res_next = scan_res;
                    end
                end
            end
            art_pkg::S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_out_next   = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= art_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            for (int i = 0; i < LISTS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            if (cnt_we) begin
                cnt_reg[rec_list] <= cnt_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        phase_reg    <= phase_next;
        list_reg     <= list_next;
        key_reg      <= key_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        m_out_reg    <= m_out_next;
    end

    // handshake outputs
    assign s_ready = (state_reg == art_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_out_reg;

endmodule

`default_nettype wire

>>> verif/address_region_range_table_unit_tb.sv
`timescale 1ns / 1ps
// testbench for the address range match table: directed and random items checked by a predictor
module address_region_range_table_unit_tb;
    import art_pkg::*;

    localparam int NODES      = 16;
    localparam int SLOTS      = 8;
    localparam int ADDR_BITS  = 48;
    localparam int LISTS      = NODES + 1;
    localparam int LOCAL_LIST = NODES;

    // longest item: three full scans of SLOTS entries plus decode and result
    localparam int IDLE_GAP    = 3 * (SLOTS + 1) + 3 + 10;
    localparam int CYCLE_LIMIT = 500000;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 220;
    // enable setting per random phase, bit p belongs to phase p
    localparam bit [RANDOM_PHASES-1:0] PHASE_ENABLE = 6'b111011;

    // func codes that the table does not know
    localparam logic [2:0] FN_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] FN_LAST_UNUSED  = 3'd7;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [CFG_DATA_BITS-1:0] pwdata  = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    address_region_range_table_unit #(
        .NODES    (NODES),
        .SLOTS    (SLOTS),
        .ADDR_BITS(ADDR_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the range lists and the registers
    logic [47:0] span_start [LISTS*SLOTS];
    logic [48:0] span_end   [LISTS*SLOTS];
    int unsigned span_count [LISTS];
    logic        tbl_enable   = 1'b0;
    logic [3:0]  tbl_own_node = 4'd0;

    in_t  pending_requests [$];
    out_t expected_results [$];

    int error_count = 0;
    int cycle_count = 0;

    // sender and receiver pacing, retuned per phase
    int  tx_gap_max     = 0;
    int  rx_stall_pct   = 0;
    int  gap_left       = 0;
    int  burst_left     = 0;
    int  rx_stall_left  = 0;
    bit  item_taken     = 1'b0;
    bit  drain_hold     = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // first entry of a list that covers the address, -1 when none does
    function automatic int first_covering(int list, logic [47:0] a);
        for (int i = 0; i < span_count[list]; i++) begin
            if (span_start[list*SLOTS+i] <= a && span_end[list*SLOTS+i] > {1'b0, a})
                return i;
        end
        return -1;
    endfunction

    function automatic out_t record_span(int list, logic [47:0] start, logic [31:0] len);
        out_t r;
        int unsigned c;
        r = '0;
        c = span_count[list];
        if (c >= SLOTS) begin
            r.status = STAT_FULL;
        end else begin
            span_start[list*SLOTS+c] = start;
            // end is one bit wider than an address, so it never wraps
            span_end[list*SLOTS+c]   = {1'b0, start} + {17'd0, len};
            span_count[list]         = c + 1;
            r.hit  = 1'b1;
            r.slot = c[2:0];
        end
        return r;
    endfunction

    // result of one item, updating the predictor's lists
    function automatic out_t predict_table_result(in_t it);
        out_t r;
        int   idx;
        bit   local_found;
        r = '0;
        r.status = STAT_OK;
        case (it.func)
            FN_REC_LOCAL: begin
                if (!tbl_enable) r.status = STAT_DISABLED;
                else r = record_span(LOCAL_LIST, it.addr, it.length);
            end
            FN_REC_NODE: begin
                // node records go in even while the table is off
                if (it.node >= NODES) r.status = STAT_BADNODE;
                else r = record_span(int'(it.node), it.addr, it.length);
            end
            FN_FIND_LOCAL: begin
                if (!tbl_enable) begin
                    r.status = STAT_DISABLED;
                end else begin
                    idx = first_covering(LOCAL_LIST, it.addr);
                    if (idx >= 0) begin
                        r.hit  = 1'b1;
                        r.slot = idx[2:0];
                    end
                end
            end
            FN_FIND_NODE: begin
                // disabled wins over bad node
                if (!tbl_enable) begin
                    r.status = STAT_DISABLED;
                end else if (it.node >= NODES) begin
                    r.status = STAT_BADNODE;
                end else begin
                    idx = first_covering(int'(it.node), it.addr);
                    if (idx >= 0) begin
                        r.hit  = 1'b1;
                        r.slot = idx[2:0];
                    end
                end
            end
            FN_FIND_BOTH: begin
                if (!tbl_enable) begin
                    r.status = STAT_DISABLED;
                end else if (it.node >= NODES) begin
                    r.status = STAT_BADNODE;
                end else begin
                    // local side: local list first, then this node's own list
                    local_found = first_covering(LOCAL_LIST, it.addr) >= 0;
                    if (!local_found && tbl_own_node < NODES)
                        local_found = first_covering(int'(tbl_own_node), it.addr) >= 0;
                    if (local_found && first_covering(int'(it.node), it.remote_addr) >= 0)
                        r.hit = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] random48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // record starts crowd into a few narrow regions so that ranges overlap
    function automatic logic [47:0] record_start();
        case ($urandom_range(0, 4))
            0:       return random48();
            1:       return 48'($urandom_range(0, 'h3FFFF));
            2:       return 48'h0000_1000_0000 + 48'($urandom_range(0, 'h3FFFF));
            3:       return 48'h7FFF_FFF0_0000 + 48'($urandom_range(0, 'h3FFFF));
            default: return 48'hFFFF_FFFC_0000 + 48'($urandom_range(0, 'h3FFFF));
        endcase
    endfunction

    function automatic logic [31:0] record_length();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 'hFFFF);
        endcase
    endfunction

    // an address inside or just outside one of the recorded ranges of a list
    function automatic logic [47:0] known_address(int list);
        int          e;
        logic [47:0] st;
        logic [48:0] en;
        logic [48:0] len;
        if (span_count[list] == 0) return random48();
        e   = list * SLOTS + $urandom_range(0, span_count[list] - 1);
        st  = span_start[e];
        en  = span_end[e];
        len = en - {1'b0, st};
        case ($urandom_range(0, 4))
            0:       return st;
            1:       return (len == 0) ? st : 48'({1'b0, st} + ({$urandom, $urandom} % len));
            2:       return 48'(en - 1);
            3:       return 48'(en);
            default: return st - 48'd1;
        endcase
    endfunction

    function automatic logic [47:0] lookup_address(int list);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return known_address(list);
        if (roll < 85) return known_address($urandom_range(0, LISTS - 1));
        return random48();
    endfunction

    function automatic in_t random_request();
        in_t it;
        int  roll;
        int  list;
        roll = $urandom_range(0, 99);
        it.node        = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(NODES, 31))
                                                     : 5'($urandom_range(0, NODES - 1));
        list           = (it.node < NODES) ? int'(it.node) : 0;
        it.addr        = random48();
        it.remote_addr = random48();
        it.length      = $urandom;
        if (roll < 12) begin
            it.func   = FN_REC_LOCAL;
            it.addr   = record_start();
            it.length = record_length();
        end else if (roll < 25) begin
            it.func   = FN_REC_NODE;
            it.addr   = record_start();
            it.length = record_length();
        end else if (roll < 45) begin
            it.func = FN_FIND_LOCAL;
            it.addr = lookup_address(LOCAL_LIST);
        end else if (roll < 70) begin
            it.func = FN_FIND_NODE;
            it.addr = lookup_address(list);
        end else if (roll < 97) begin
            it.func        = FN_FIND_BOTH;
            it.addr        = $urandom_range(0, 1) ? lookup_address(LOCAL_LIST)
                                                  : lookup_address(int'(tbl_own_node));
            it.remote_addr = lookup_address(list);
        end else begin
            it.func = 3'($urandom_range(32'(FN_FIRST_UNUSED), 32'(FN_LAST_UNUSED)));
        end
        return it;
    endfunction

    task automatic queue_item(logic [2:0] f, logic [4:0] n, logic [47:0] a,
                              logic [47:0] ra, logic [31:0] len);
        in_t it;
        it.func        = f;
        it.node        = n;
        it.addr        = a;
        it.remote_addr = ra;
        it.length      = len;
        pending_requests.push_back(it);
    endtask

    // register write: setup cycle, then access cycle; lands on the access edge
    task automatic write_register(logic reg_idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_ENABLE) tbl_enable = value[0];
        else tbl_own_node = value[3:0];
        @(posedge aclk);
    endtask

    // block idle: nothing queued, nothing in flight, then a wait covering the longest item
    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    // sender: bursts of items with random gaps, now and then waiting for a full drain
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
            if (drain_hold || pending_requests.size() == 0) begin
                s_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_data  <= pending_requests.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (tx_gap_max == 0) ? 0 : $urandom_range(1, tx_gap_max);
                end
                if ($urandom_range(0, 99) == 0) drain_hold = 1'b1;
            end
        end
        item_taken = 1'b0;
    end

    // receiver: stalls of random length at a per-phase rate
    always @(negedge aclk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rx_stall_left = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: check each result item, then predict each accepted item
    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(m_data), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.hit !== want.hit)
                    report_mismatch("hit", 64'(m_data.hit), 64'(want.hit));
                if (m_data.slot !== want.slot)
                    report_mismatch("slot", 64'(m_data.slot), 64'(want.slot));
                if (m_data.status !== want.status)
                    report_mismatch("status", 64'(m_data.status), 64'(want.status));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(predict_table_result(s_data));
            item_taken = 1'b1;
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [3:0] own;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // table off after reset: only node records and unknown funcs get through; finds and local records see disabled
        tx_gap_max   = 3;
        rx_stall_pct = 20;
        queue_item(FN_REC_NODE,   5'd0,  48'h2000, 48'h0,    32'h800);
        queue_item(FN_REC_LOCAL,  5'd0,  48'h100,  48'h0,    32'h10);
        queue_item(FN_FIND_LOCAL, 5'd0,  48'h2000, 48'h0,    32'h0);
        queue_item(FN_FIND_NODE,  5'd0,  48'h2000, 48'h0,    32'h0);
        queue_item(FN_FIND_NODE,  5'd31, 48'h2000, 48'h0,    32'h0);
        queue_item(FN_FIND_BOTH,  5'd0,  48'h2000, 48'h2000, 32'h0);
        queue_item(FN_REC_NODE,   5'd31, 48'h0,    48'h0,    32'h10);
        queue_item(FN_FIRST_UNUSED, 5'd0, 48'h2000, 48'h0,   32'h0);
        queue_item(FN_LAST_UNUSED,  5'd31, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                   32'hFFFF_FFFF);
        wait_idle();

        write_register(REG_ENABLE, 32'd1);
        write_register(REG_OWN_NODE, 32'd15);
        // zero length covers nothing; a range at the top of the space does not wrap
        queue_item(FN_REC_LOCAL,  5'd0,  48'h0,             48'h0, 32'h0);
        queue_item(FN_REC_LOCAL,  5'd0,  48'hFFFF_FFFF_FFFF, 48'h0, 32'hFFFF_FFFF);
        queue_item(FN_FIND_LOCAL, 5'd0,  48'hFFFF_FFFF_FFFF, 48'h0, 32'h0);
        queue_item(FN_FIND_LOCAL, 5'd0,  48'h0,             48'h0, 32'h0);
        queue_item(FN_REC_NODE,   5'd15, 48'h1000,          48'h0, 32'h100);
        queue_item(FN_FIND_NODE,  5'd15, 48'h10FF,          48'h0, 32'h0);
        queue_item(FN_FIND_NODE,  5'd15, 48'h1100,          48'h0, 32'h0);
        // local side found only through the own node's list
        queue_item(FN_FIND_BOTH,  5'd0,  48'h1080,          48'h2100, 32'h0);
        // local side in the local list, remote side missing
        queue_item(FN_FIND_BOTH,  5'd0,  48'hFFFF_FFFF_FFFF, 48'h2800, 32'h0);
        queue_item(FN_FIND_NODE,  5'd31, 48'h1000,          48'h0, 32'h0);
        queue_item(FN_REC_NODE,   5'd16, 48'h1000,          48'h0, 32'h100);
        queue_item(FN_FIND_BOTH,  5'd20, 48'h1080,          48'h2100, 32'h0);
        // one record past a full list
        for (int i = 0; i <= SLOTS; i++)
            queue_item(FN_REC_NODE, 5'd3, 48'h4000 + 48'(i * 'h100), 48'h0, 32'h80);
        wait_idle();

        // random phases over several register settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin own = 4'd0;  tx_gap_max = 0;  rx_stall_pct = 0;  end
                1: begin own = 4'd15; tx_gap_max = 6;  rx_stall_pct = 25; end
                2: begin own = 4'd5;  tx_gap_max = 20; rx_stall_pct = 60; end
                3: begin own = 4'($urandom); tx_gap_max = 0; rx_stall_pct = 40; end
                4: begin own = 4'd3;  tx_gap_max = 6;  rx_stall_pct = 10; end
                default: begin own = 4'($urandom); tx_gap_max = 20; rx_stall_pct = 0; end
            endcase
            write_register(REG_ENABLE, {31'd0, PHASE_ENABLE[p]});
            write_register(REG_OWN_NODE, {28'd0, own});
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_requests.push_back(random_request());
            wait_idle();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/art_pkg.sv
hdl/art_ram.sv
hdl/art_match.sv
hdl/address_region_range_table_unit.sv
verif/address_region_range_table_unit_tb.sv
